// ----- sv/ffra_pkg.sv -----
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants of the frame-fenced ring allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

	// Ring sizing
	localparam int unsigned QUEUE_DEPTH = 64;
	localparam int unsigned ALIGN_BYTES = 256;
	localparam int unsigned MAX_BYTES   = 16777216;

	// Field widths fixed by the interface
	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned SZ_W     = 25;
	localparam int unsigned FRAME_W  = 32;
	localparam int unsigned OFS_W    = 24;
	localparam int unsigned ADDR_W   = 64;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FREED_W  = 7;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 64;

	// Derived widths
	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Command queue between front and back end
	localparam int unsigned CMDQ_DEPTH = 2;
	localparam int unsigned CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// Configuration register indices
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = CFG_IDX_W'(1);

	// Reset value of the region size register
	localparam logic [SZ_W-1:0] TOTAL_SIZE_RST = SZ_W'(16777216);

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC = 2'd0,
		FN_FREE  = 2'd1,
		FN_RESET = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD_SIZE = 2'd2,
		ST_Q_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FREE_START,
		BK_FREE_WALK
	} bk_state_t;

	// Classified request handed from front to back end
	typedef struct packed {
		func_t             func;
		logic              bad;
		logic [SZ_W-1:0]   size;
		logic [FRAME_W-1:0] frame;
	} cmd_t;

	// One allocation record
	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [OFS_W-1:0]   offset;
		logic [SZ_W-1:0]    size;
	} rec_t;

	// One result
	typedef struct packed {
		status_t            status;
		logic [ADDR_W-1:0]  address;
		logic [OFS_W-1:0]   offset;
		logic [FREED_W-1:0] freed;
	} res_t;

endpackage

// ----- sv/ffra_front.sv -----
// ----------------------------------------------------------------------------
// ffra_front
// Request intake: align the size and flag zero sizes and sizes the region cannot hold.
// ----------------------------------------------------------------------------
module ffra_front import ffra_pkg::*; (
	input  logic               push,
	output logic               full,
	input  logic [FUNC_W-1:0]  func,
	input  logic [SZ_W-1:0]    req_size,
	input  logic [FRAME_W-1:0] frame,
	input  logic [SZ_W-1:0]    eff_size,
	input  logic               q_full,
	output logic               cmd_push,
	output cmd_t               cmd
);

	localparam logic [SZ_W:0] ALIGN_M1 = (SZ_W+1)'(ALIGN_BYTES - 1);

	logic [SZ_W:0] sum;
	logic [SZ_W:0] aligned;

	always_comb begin
		sum     = {1'b0, req_size} + ALIGN_M1;
		aligned = sum & ~ALIGN_M1;
		cmd.func  = func_t'(func);
		cmd.size  = aligned[SZ_W-1:0];
		cmd.frame = frame;
		cmd.bad   = (aligned == '0) || (aligned > {1'b0, eff_size});
	end

	assign full     = q_full;
	assign cmd_push = push & ~q_full;

endmodule

// ----- sv/ffra_cmdq.sv -----
// ----------------------------------------------------------------------------
// ffra_cmdq
// Short command queue decoupling intake from execution.
// ----------------------------------------------------------------------------
module ffra_cmdq import ffra_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic q_full,
	input  logic rd_en,
	output logic rd_valid,
	output cmd_t rd_cmd
);

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	function automatic logic [CMDQ_PTR_W-1:0] bump(input logic [CMDQ_PTR_W-1:0] p);
		logic [CMDQ_PTR_W-1:0] r;
		r = (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	assign q_full   = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = entry_q[rd_ptr_q];
	assign do_wr    = wr_en & ~q_full;
	assign do_rd    = rd_en & rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= bump(wr_ptr_q);
			if (do_rd) rd_ptr_q <= bump(rd_ptr_q);
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) entry_q[wr_ptr_q] <= wr_cmd;
	end

endmodule

// ----- sv/ffra_back.sv -----
// ----------------------------------------------------------------------------
// ffra_back
// Execution: ring placement, record queue, free walk and result register.
// ----------------------------------------------------------------------------
module ffra_back import ffra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	input  logic [SZ_W-1:0]   eff_size,
	input  logic [ADDR_W-1:0] base_addr,
	output logic              res_valid,
	output res_t              res,
	input  logic              res_pop
);

	bk_state_t state_q, state_d;

	logic [SZ_W-1:0]    head_q, head_d;
	logic [SZ_W-1:0]    tail_q, tail_d;
	logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
	logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   freed_q, freed_d;
	logic [FRAME_W-1:0] fence_q, fence_d;
	logic               res_valid_q, res_valid_d;
	res_t               res_q, res_d;

	rec_t mem [QUEUE_DEPTH];
	rec_t rd_rec_q;
	logic mem_we;
	rec_t mem_wdata;

	logic              slot_free;
	logic [SZ_W:0]     tail_end;
	logic [SZ_W:0]     at_end;
	logic [SZ_W:0]     head_end;
	logic [ADDR_W-1:0] addr_tail;
	logic              use_tail;
	logic              use_zero;
	logic [SZ_W-1:0]   at;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	assign slot_free = ~res_valid_q | res_pop;
	assign addr_tail = base_addr + {{(ADDR_W-SZ_W){1'b0}}, tail_q};
	assign tail_end  = {1'b0, tail_q} + {1'b0, cmd.size};
	assign head_end  = {1'b0, head_q} + {1'b0, rd_rec_q.size};

	// Placement: at the tail, else wrapped to zero below the head
	always_comb begin
		use_tail = 1'b0;
		use_zero = 1'b0;
		if (tail_q >= head_q) begin
			if (tail_end <= {1'b0, eff_size}) use_tail = 1'b1;
			else if (cmd.size <= head_q) use_zero = 1'b1;
		end else if (tail_end <= {1'b0, head_q}) begin
			use_tail = 1'b1;
		end
		at     = use_tail ? tail_q : '0;
		at_end = {1'b0, at} + {1'b0, cmd.size};
	end

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		rd_ptr_d    = rd_ptr_q;
		wr_ptr_d    = wr_ptr_q;
		count_d     = count_q;
		freed_d     = freed_q;
		fence_d     = fence_q;
		res_valid_d = res_valid_q & ~res_pop;
		res_d       = res_q;
		cmd_pop     = 1'b0;
		mem_we      = 1'b0;
		mem_wdata   = '{frame: cmd.frame, offset: at[OFS_W-1:0], size: cmd.size};

		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && slot_free) begin
					cmd_pop = 1'b1;
					res_d   = '{status: ST_OK, address: '0, offset: '0, freed: '0};
					res_valid_d = 1'b1;
					case (cmd.func)
						FN_ALLOC: begin
							if (cmd.bad) begin
								res_d.status = ST_BAD_SIZE;
							end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
								res_d.status = ST_Q_FULL;
							end else if (!(use_tail || use_zero)) begin
								res_d.status = ST_NO_SPACE;
							end else begin
								// grant: record it and advance the tail
								tail_d   = at_end[SZ_W-1:0];
								mem_we   = 1'b1;
								wr_ptr_d = bump(wr_ptr_q);
								count_d  = count_q + 1'b1;
								res_d.offset  = at[OFS_W-1:0];
								res_d.address = use_tail ? addr_tail : base_addr;
							end
						end
						FN_FREE: begin
							// result waits for the walk to finish
							res_valid_d = 1'b0;
							fence_d     = cmd.frame;
							freed_d     = '0;
							state_d     = BK_FREE_START;
						end
						FN_RESET: begin
							head_d   = '0;
							tail_d   = '0;
							rd_ptr_d = '0;
							wr_ptr_d = '0;
							count_d  = '0;
						end
						default: begin
						end
					endcase
				end
			end
			BK_FREE_START: begin
				// let the record read register settle on the oldest record
				state_d = BK_FREE_WALK;
			end
			BK_FREE_WALK: begin
				if ((count_q != '0) && (rd_rec_q.frame < fence_q)) begin
					if ({{(SZ_W-OFS_W){1'b0}}, rd_rec_q.offset} == head_q) begin
						head_d = (head_end >= {1'b0, eff_size}) ? '0 : head_end[SZ_W-1:0];
					end
					rd_ptr_d = bump(rd_ptr_q);
					count_d  = count_q - 1'b1;
					freed_d  = freed_q + 1'b1;
				end else begin
					if (count_q == '0) head_d = tail_q;
					res_d = '{status: ST_OK, address: '0, offset: '0,
						freed: FREED_W'(freed_q)};
					res_valid_d = 1'b1;
					state_d     = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			rd_ptr_q    <= rd_ptr_d;
			wr_ptr_q    <= wr_ptr_d;
			count_q     <= count_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		freed_q <= freed_d;
		fence_q <= fence_d;
		res_q   <= res_d;
	end

	// Record store: one write port, registered read that follows the next read pointer
	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_ptr_q] <= mem_wdata;
		rd_rec_q <= mem[rd_ptr_d];
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- sv/frame_fenced_ring_allocator.sv -----
// ----------------------------------------------------------------------------
// frame_fenced_ring_allocator
// Ring allocator over an upload region with per-frame release of grants.
// ----------------------------------------------------------------------------
// Requests enter through a queue-style port (push/full) and each gives exactly
// one result, read out through empty/pop in request order. A front end rounds
// the size up to the alignment and flags bad sizes; a two-entry command queue
// hands the request to the back end, which owns head, tail and the 64-entry
// record store. Allocate, reset and unused requests run at one per clock once
// the pipe is primed and while the result register is free or being popped;
// each is registered in the command queue and then in the result register.
// A free request first takes the request, then lines the record read register
// up on the oldest record, then releases one record per cycle through the
// store's single read port, and ends with a step that finds the end of the
// walk and loads the result. The back end takes the next request only when
// the result register is free or is being popped in the same cycle. Write the
// configuration registers (index 0 region size, index 1 base address) only
// while no request is in flight; writes never move head, tail or the records.
// ----------------------------------------------------------------------------
module frame_fenced_ring_allocator import ffra_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request side
	input  logic                  push,
	output logic                  full,
	input  logic [FUNC_W-1:0]     func,
	input  logic [SZ_W-1:0]       req_size,
	input  logic [FRAME_W-1:0]    frame,
	// result side
	output logic                  empty,
	input  logic                  pop,
	output logic [STATUS_W-1:0]   status,
	output logic [ADDR_W-1:0]     address,
	output logic [OFS_W-1:0]      offset,
	output logic [FREED_W-1:0]    freed_count,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SZ_W-1:0]   total_size_q;
	logic [ADDR_W-1:0] base_addr_q;
	logic [SZ_W-1:0]   eff_size;

	logic q_full;
	logic cmd_push;
	cmd_t front_cmd;
	logic cmd_valid;
	cmd_t back_cmd;
	logic cmd_pop;
	logic res_valid;
	res_t res;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_size_q <= TOTAL_SIZE_RST;
			base_addr_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TOTAL_SIZE:   total_size_q <= cfg_data[SZ_W-1:0];
				REG_BASE_ADDRESS: base_addr_q  <= cfg_data[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the region to the largest size the ring supports
	assign eff_size = (total_size_q > SZ_W'(MAX_BYTES)) ? SZ_W'(MAX_BYTES) : total_size_q;

	ffra_front u_front (
		.push     (push),
		.full     (full),
		.func     (func),
		.req_size (req_size),
		.frame    (frame),
		.eff_size (eff_size),
		.q_full   (q_full),
		.cmd_push (cmd_push),
		.cmd      (front_cmd)
	);

	ffra_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_cmd   (front_cmd),
		.q_full   (q_full),
		.rd_en    (cmd_pop),
		.rd_valid (cmd_valid),
		.rd_cmd   (back_cmd)
	);

	ffra_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (back_cmd),
		.cmd_pop   (cmd_pop),
		.eff_size  (eff_size),
		.base_addr (base_addr_q),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (pop)
	);

	// Present the held result
	assign empty       = ~res_valid;
	assign status      = res.status;
	assign address     = res.address;
	assign offset      = res.offset;
	assign freed_count = res.freed;

endmodule
